// File: rtl/core/sscod_pkg.sv
// ----------------------------------------------------------------------------
// sscod_pkg: shared types and constants for the stereo overdrive core
// Fixed-point formats, register codes and limits, the shared serial
// multiplier/divider widths, and the control structs between top and lanes.
// ----------------------------------------------------------------------------
package sscod_pkg;

  // Default sample width (signed Q1.(SAMPLE_BITS-1))
  localparam int SAMPLE_BITS_DEF = 24;

  // Fractional bits of the internal formats
  localparam int X_FRAC     = 23;  // drive-scaled sample x
  localparam int ST_FRAC    = 30;  // clip output, filter state, coefficient
  localparam int DRIVE_FRAC = 12;
  localparam int TONE_FRAC  = 16;
  localparam int LEVEL_FRAC = 16;

  // Serial multiplier: MW x MW operands, two multiplier bits per step
  localparam int MW        = 32;
  localparam int PW        = 2 * MW;
  localparam int MUL_STEPS = MW / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Datapath widths
  localparam int XMAG_W = 27;  // |x| up to 10.0 in Q.23
  localparam int M_W    = 25;  // |x| up to 3.0 in Q.23
  localparam int X2_W   = 27;  // x^2 up to 9.0 in Q.23
  localparam int NF_W   = 29;  // 27 + x^2
  localparam int DEN_W  = 30;  // 27 + 9x^2
  localparam int Q_W    = 31;  // clip quotient, up to 1.0 in Q.30
  localparam int NUM_W  = DEN_W + Q_W;
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int COEF_W = 29;
  localparam int ST_W   = 32;

  // Configuration port
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 17;
  localparam int DRIVE_W = 16;
  localparam int TONE_W  = 17;
  localparam int LEVEL_W = 17;

  localparam logic [IDX_W-1:0] REG_DRIVE = 2'd0;
  localparam logic [IDX_W-1:0] REG_TONE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_LEVEL = 2'd2;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN = 16'd4096;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'd40960;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd8192;
  localparam logic [TONE_W-1:0]  TONE_MAX  = 17'd65536;
  localparam logic [TONE_W-1:0]  TONE_RST  = 17'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_RST = 17'd65536;

  // Lowpass coefficient c = 0.01 + 0.3 * tone, Q.30
  localparam logic [COEF_W-1:0] C_BASE  = 29'd10737418;
  localparam logic [MW-1:0]     C_SLOPE = 32'd322122547;

  // Soft clip constants in Q.23
  localparam logic [XMAG_W-1:0] CLIP_LIM = 27'd25165824;   // 3.0
  localparam logic [DEN_W-1:0]  NF_BASE  = 30'd226492416;  // 27.0

  // Unity in Q.30
  localparam logic signed [ST_W-1:0] ONE30     = 32'sd1073741824;
  localparam logic signed [ST_W-1:0] NEG_ONE30 = -32'sd1073741824;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [TONE_W-1:0]  tone;
    logic [LEVEL_W-1:0] level;
  } cfg_t;

  typedef struct packed {
    logic start;  // launch a new sample pair
    logic take;   // result moved to the output register
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

// File: rtl/core/sscod_ser_mul.sv
// ----------------------------------------------------------------------------
// sscod_ser_mul: digit-serial unsigned multiplier
// Consumes the multiplier operand two bits per cycle, least significant
// digit first, adding 0, a, 2a or 3a into the upper half of a shift register.
// ----------------------------------------------------------------------------
module sscod_ser_mul import sscod_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  output logic          done,
  output logic [PW-1:0] prod
);

  localparam int AW = MW + 2;

  logic [MW-1:0]        a_r;
  logic [AW-1:0]        a3_r;
  logic [PW-1:0]        p;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [AW-1:0]        addend;
  logic [AW-1:0]        sum;

  // Select the partial product for the current digit
  always_comb begin
    unique case (p[1:0])
      2'd0: addend = '0;
      2'd1: addend = AW'(a_r);
      2'd2: addend = AW'({a_r, 1'b0});
      2'd3: addend = a3_r;
    endcase
    sum = AW'(p[PW-1:MW]) + addend;
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Load operands, then shift in one digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      a3_r <= AW'(a) + AW'({a, 1'b0});
      p    <= {{MW{1'b0}}, b};
      cnt  <= '0;
    end else if (busy) begin
      p   <= {sum, p[MW-1:2]};
      cnt <= cnt + 1'b1;
    end
  end

  assign prod = p;

endmodule

// File: rtl/core/sscod_ser_div.sv
// ----------------------------------------------------------------------------
// sscod_ser_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the partial remainder and the
// remaining dividend bits share one shift register.
// ----------------------------------------------------------------------------
module sscod_ser_div import sscod_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic [NUM_W-1:0]     acc;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W:0]       top_bits;
  logic [DEN_W+1:0]     trial;
  logic                 fits;
  logic [DEN_W-1:0]     rem_next;

  // Bring down the next bit and try the subtraction
  always_comb begin
    top_bits = acc[NUM_W-1 -: DEN_W+1];
    trial    = {1'b0, top_bits} - {2'b00, den_r};
    fits     = !trial[DEN_W+1];
    rem_next = fits ? trial[DEN_W-1:0] : top_bits[DEN_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(Q_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Load the dividend, then shift quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      acc <= {rem_next, acc[Q_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  assign quot = acc[Q_W-1:0];

endmodule

// File: rtl/core/sscod_lane.sv
// ----------------------------------------------------------------------------
// sscod_lane: one channel of the overdrive
// Sequences drive gain, soft clip, one-pole lowpass and output level through
// a shared digit-serial multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module sscod_lane import sscod_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lane_ctl_t              ctl,
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] sample,
  output lane_stat_t             stat,
  output logic [SAMPLE_BITS-1:0] result
);

  localparam int GAIN_SH = (SAMPLE_BITS - 1) + DRIVE_FRAC - X_FRAC;
  localparam int LVL_SH  = ST_FRAC + LEVEL_FRAC - (SAMPLE_BITS - 1);
  localparam int NUM_SH  = ST_FRAC - X_FRAC;

  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ST_W:0]   S_HI    = (ST_W + 1)'(ONE30);
  localparam logic signed [ST_W:0]   S_LO    = -S_HI;

  localparam logic [3:0] L_IDLE = 4'd0;
  localparam logic [3:0] L_COEF = 4'd1;
  localparam logic [3:0] L_GAIN = 4'd2;
  localparam logic [3:0] L_SQR  = 4'd3;
  localparam logic [3:0] L_NUMR = 4'd4;
  localparam logic [3:0] L_DIVD = 4'd5;
  localparam logic [3:0] L_DIFF = 4'd6;
  localparam logic [3:0] L_FILT = 4'd7;
  localparam logic [3:0] L_LEVL = 4'd8;
  localparam logic [3:0] L_DONE = 4'd9;

  logic [3:0] state;
  logic       launch;

  // Payload registers
  logic                    neg_in;
  logic [SAMPLE_BITS-1:0]  mag_in;
  logic [COEF_W-1:0]       coef;
  logic [M_W-1:0]          m;
  logic [NF_W-1:0]         nf;
  logic [DEN_W-1:0]        den;
  logic signed [ST_W-1:0]  d;
  logic [MW-1:0]           dmag;
  logic                    dneg;
  logic signed [ST_W-1:0]  s;

  // Arithmetic units
  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_prod;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [Q_W-1:0]   div_quot;

  // Derived values
  logic [COEF_W-1:0]      coef_next;
  logic [XMAG_W-1:0]      x_mag;
  logic                   clip;
  logic signed [ST_W-1:0] d_clip;
  logic [X2_W-1:0]        x2;
  logic [NF_W-1:0]        nf_next;
  logic [DEN_W-1:0]       den_next;
  logic [ST_W-1:0]        d_q;
  logic [ST_W-1:0]        d_div;
  logic [ST_W:0]          diff_w;
  logic [ST_W:0]          diff_neg;
  logic [MW-1:0]          dmag_next;
  logic [Q_W-1:0]         t_mag;
  logic [ST_W:0]          t_ext;
  logic signed [ST_W:0]   s_sum;
  logic signed [ST_W:0]   s_clamp;
  logic [MW-1:0]          smag;
  logic                   s_neg;
  logic [SAMPLE_BITS-1:0] o_mag;
  logic [SAMPLE_BITS-1:0] o_val;

  sscod_ser_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sscod_ser_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign mul_start = launch && (state != L_DIVD);
  assign div_start = launch && (state == L_DIVD);

  // Numerator m*(27+x^2), scaled so the quotient is in Q.30, straight off the held product
  assign div_num = NUM_W'(mul_prod) << NUM_SH;

  // Route operands for the multiply of the current step
  always_comb begin
    unique case (state)
      L_COEF: begin
        mul_a = C_SLOPE;
        mul_b = MW'(cfg.tone);
      end
      L_GAIN: begin
        mul_a = MW'(mag_in);
        mul_b = MW'(cfg.drive);
      end
      L_SQR: begin
        mul_a = MW'(m);
        mul_b = MW'(m);
      end
      L_NUMR: begin
        mul_a = MW'(m);
        mul_b = MW'(nf);
      end
      L_FILT: begin
        mul_a = MW'(coef);
        mul_b = dmag;
      end
      L_LEVL: begin
        mul_a = smag;
        mul_b = MW'(cfg.level);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Results of each step, floor semantics kept on sign-magnitude values
  always_comb begin
    coef_next = C_BASE + mul_prod[TONE_FRAC +: COEF_W];

    // negative x rounds its magnitude up
    x_mag  = mul_prod[GAIN_SH +: XMAG_W]
           + XMAG_W'(neg_in && (|mul_prod[GAIN_SH-1:0]));
    clip   = x_mag > CLIP_LIM;
    d_clip = neg_in ? NEG_ONE30 : ONE30;

    // 9*x^2 as 8*x^2 + x^2
    x2       = mul_prod[X_FRAC +: X2_W];
    nf_next  = NF_W'(NF_BASE) + NF_W'(x2);
    den_next = NF_BASE + DEN_W'({x2, 3'b000}) + DEN_W'(x2);

    d_q   = ST_W'(div_quot);
    d_div = neg_in ? -d_q : d_q;

    diff_w    = {d[ST_W-1], d} - {s[ST_W-1], s};
    diff_neg  = -diff_w;
    dmag_next = diff_w[ST_W] ? MW'(diff_neg) : MW'(diff_w);

    t_mag = mul_prod[ST_FRAC +: Q_W] + Q_W'(dneg && (|mul_prod[ST_FRAC-1:0]));
    t_ext = {2'b00, t_mag};
    s_sum = {s[ST_W-1], s} + (dneg ? -t_ext : t_ext);
    if (s_sum > S_HI) begin
      s_clamp = S_HI;
    end else if (s_sum < S_LO) begin
      s_clamp = S_LO;
    end else begin
      s_clamp = s_sum;
    end

    s_neg = s[ST_W-1];
    smag  = s_neg ? MW'(-s) : MW'(s);
    o_mag = mul_prod[LVL_SH +: SAMPLE_BITS]
          + SAMPLE_BITS'(s_neg && (|mul_prod[LVL_SH-1:0]));
    if (s_neg) begin
      o_val = -o_mag;
    end else if (o_mag[SAMPLE_BITS-1]) begin
      o_val = OUT_MAX;
    end else begin
      o_val = o_mag;
    end
  end

  // Step sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      launch <= 1'b0;
      s      <= '0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (ctl.start) begin
            state  <= L_COEF;
            launch <= 1'b1;
          end
        end
        L_COEF: begin
          if (mul_done) begin
            state  <= L_GAIN;
            launch <= 1'b1;
          end
        end
        L_GAIN: begin
          if (mul_done) begin
            if (clip) begin
              state <= L_DIFF;
            end else begin
              state  <= L_SQR;
              launch <= 1'b1;
            end
          end
        end
        L_SQR: begin
          if (mul_done) begin
            state  <= L_NUMR;
            launch <= 1'b1;
          end
        end
        L_NUMR: begin
          if (mul_done) begin
            state  <= L_DIVD;
            launch <= 1'b1;
          end
        end
        L_DIVD: begin
          if (div_done) begin
            state <= L_DIFF;
          end
        end
        L_DIFF: begin
          state  <= L_FILT;
          launch <= 1'b1;
        end
        L_FILT: begin
          if (mul_done) begin
            s      <= ST_W'(s_clamp);
            state  <= L_LEVL;
            launch <= 1'b1;
          end
        end
        L_LEVL: begin
          if (mul_done) begin
            state <= L_DONE;
          end
        end
        L_DONE: begin
          if (ctl.take) begin
            state <= L_IDLE;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // Capture step results
  always_ff @(posedge clk) begin
    if (state == L_IDLE && ctl.start) begin
      neg_in <= sample[SAMPLE_BITS-1];
      mag_in <= sample[SAMPLE_BITS-1] ? -sample : sample;
    end
    if (state == L_COEF && mul_done) begin
      coef <= coef_next;
    end
    if (state == L_GAIN && mul_done) begin
      m <= x_mag[M_W-1:0];
      d <= d_clip;
    end
    if (state == L_SQR && mul_done) begin
      nf  <= nf_next;
      den <= den_next;
    end
    if (state == L_DIVD && div_done) begin
      d <= d_div;
    end
    if (state == L_DIFF) begin
      dmag <= dmag_next;
      dneg <= diff_w[ST_W];
    end
    if (state == L_LEVL && mul_done) begin
      result <= o_val;
    end
  end

  assign stat.idle = (state == L_IDLE);
  assign stat.done = (state == L_DONE);

  // Filter state stays within -1.0 .. +1.0
  a_state_bound: assert property (@(posedge clk) disable iff (rst)
    (s <= ONE30) && (s >= NEG_ONE30))
    else $error("filter state out of range");

  // Multiplier finishes only in a multiply step
  a_mul_step: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == L_COEF || state == L_GAIN || state == L_SQR ||
                  state == L_NUMR || state == L_FILT || state == L_LEVL))
    else $error("multiply result outside a multiply step");

  // Divider finishes only in the divide step
  a_div_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == L_DIVD))
    else $error("divide result outside the divide step");

endmodule

// File: rtl/core/stereo_soft_clip_overdrive_core.sv
// Steps per sample pair: six multiply steps, a divide step, a difference
//   step and a load of the output register; a channel that hits the hard
//   clip skips the square, numerator and divide steps, and the slower
//   channel sets when the pair completes. A new pair is accepted only
//   after both lanes have handed their results to the output register.
// Reset: synchronous; restores register defaults, clears both filter states.
// ----------------------------------------------------------------------------
// stereo_soft_clip_overdrive_core: stereo drive, soft clip, tone and level
// Two channel lanes run side by side on each accepted sample pair; an output
// register holds the result so the next pair can enter while it waits.
// ----------------------------------------------------------------------------
module stereo_soft_clip_overdrive_core import sscod_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] left_sample,
  input  logic [SAMPLE_BITS-1:0] right_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] left_out,
  output logic [SAMPLE_BITS-1:0] right_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cfg_t                   cfg_r;
  lane_ctl_t              ctl;
  lane_stat_t             l_stat, r_stat;
  logic [SAMPLE_BITS-1:0] l_res, r_res;
  logic [DRIVE_W-1:0]     drive_raw, drive_wr;
  logic [TONE_W-1:0]      tone_wr;
  logic [LEVEL_W-1:0]     level_wr;

  // Clamp register writes
  always_comb begin
    drive_raw = cfg_data[DRIVE_W-1:0];
    if (drive_raw < DRIVE_MIN) begin
      drive_wr = DRIVE_MIN;
    end else if (drive_raw > DRIVE_MAX) begin
      drive_wr = DRIVE_MAX;
    end else begin
      drive_wr = drive_raw;
    end
    tone_wr  = (TONE_W'(cfg_data) > TONE_MAX) ? TONE_MAX : TONE_W'(cfg_data);
    level_wr = (LEVEL_W'(cfg_data) > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(cfg_data);
  end

  assign cfg_ready = 1'b1;

  // Configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.drive <= DRIVE_RST;
      cfg_r.tone  <= TONE_RST;
      cfg_r.level <= LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DRIVE: cfg_r.drive <= drive_wr;
        REG_TONE:  cfg_r.tone  <= tone_wr;
        REG_LEVEL: cfg_r.level <= level_wr;
        default: begin
        end
      endcase
    end
  end

  // Accept a request when both lanes are free; move results when both finish
  assign in_ready  = l_stat.idle && r_stat.idle;
  assign ctl.start = in_valid && in_ready;
  assign ctl.take  = l_stat.done && r_stat.done && (!out_valid || out_ready);

  sscod_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .sample (left_sample),
    .stat   (l_stat),
    .result (l_res)
  );

  sscod_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .sample (right_sample),
    .stat   (r_stat),
    .result (r_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      left_out  <= l_res;
      right_out <= r_res;
    end
  end

  // Lanes leave idle right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while lanes stay idle");

  // Drive write lands inside its clamp range
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_index == REG_DRIVE) |=>
      (cfg_r.drive >= DRIVE_MIN) && (cfg_r.drive <= DRIVE_MAX))
    else $error("drive gain outside clamp range");

  // Tone and level never exceed unity
  a_tone_level: assert property (@(posedge clk) disable iff (rst)
    (cfg_r.tone <= TONE_MAX) && (cfg_r.level <= LEVEL_MAX))
    else $error("tone or level outside range");

endmodule
